/* rtl/core/mavg_pkg.sv */
// Shared types and constants for the moving average window core.
// Used by every module under rtl/core; depends on nothing else.
package mavg_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int SUM_W              = 22;
  localparam int CNT_W              = 7;
  localparam int DEFAULT_MAX_WINDOW = 64;
  localparam int Q_DEPTH            = 2;

  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(16);

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } q_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_UPDATE,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/mavg_front.sv */
// Input side of the moving average core: accepts items and queues them.
// Depends on mavg_pkg for the queued item type.
module mavg_front
  import mavg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,
  input  logic                in_tuser,
  output q_item_t             item,
  output logic                item_valid,
  input  logic                item_pop
);

  // The queue depth is a power of two so the pointers wrap on their own.
  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W  = $clog2(Q_DEPTH + 1);

  q_item_t           q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   q_cnt_r, q_cnt_nxt;
  logic              push, pop;
  q_item_t           new_item;

  assign in_tready  = (q_cnt_r != QC_W'(Q_DEPTH));
  assign item_valid = (q_cnt_r != '0);
  assign item       = q_mem_r[rd_ptr_r];

  assign push = in_tvalid && in_tready;
  assign pop  = item_pop && item_valid;

  always_comb begin
    new_item.cmd    = cmd_t'(in_tuser);
    new_item.sample = $signed(in_tdata);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   q_cnt_nxt = q_cnt_r + QC_W'(1);
      2'b01:   q_cnt_nxt = q_cnt_r - QC_W'(1);
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* rtl/core/mavg_div.sv */
// Bit-serial signed divider for the running sum, one quotient bit per cycle.
// Depends on mavg_pkg for widths and the request/response structs.
module mavg_div
  import mavg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [SAMPLE_W-1:0] sat_q;

  // Magnitude of the most negative sum still fits the unsigned width.
  assign mag = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);

  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag;
      dvs_r <= req.divisor;
      neg_r <= req.dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Saturate the truncated quotient to the signed sample range.
  always_comb begin
    if (!neg_r) begin
      if (quo_r > SUM_W'(32767)) sat_q = 16'h7FFF;
      else                       sat_q = quo_r[SAMPLE_W-1:0];
    end else begin
      if (quo_r > SUM_W'(32768)) sat_q = 16'h8000;
      else                       sat_q = SAMPLE_W'(-quo_r[SAMPLE_W-1:0]);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = $signed(sat_q);

endmodule

/* rtl/core/mavg_back.sv */
// Execution side of the moving average core: sample ring, running sum,
// fill count, division sequencing and the result register. Uses mavg_pkg.
module mavg_back
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CNT_W-1:0]    window_length,
  input  q_item_t             item,
  input  logic                item_valid,
  output logic                item_pop,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_average,
  output logic                out_full,
  output logic [CNT_W-1:0]    out_fill
);

  localparam int HW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int MAX_LEN = (MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW;
  localparam int CW      = (HW > CNT_W) ? HW : CNT_W;
  localparam int CW1     = CW + 1;

  back_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] ring_r [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rdata_r;
  q_item_t                    item_r;
  logic [HW-1:0]              idx_r;
  logic [HW-1:0]              head_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] avg_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_avg_r;
  logic                       out_full_r;
  logic [CNT_W-1:0]           out_fill_r;

  logic [CNT_W-1:0]        len;
  logic [HW-1:0]           head_eff;
  logic                    was_full;
  logic [CW1-1:0]          next_pos;
  logic [HW-1:0]           head_upd;
  logic [CNT_W-1:0]        count_upd;
  logic signed [SUM_W-1:0] sum_upd;
  logic                    ring_we;
  logic                    rd_en;
  logic                    out_load;

  // A zero length acts as one; lengths past the ring depth saturate.
  always_comb begin
    if (window_length == '0)                      len = CNT_W'(1);
    else if (window_length > CNT_W'(MAX_LEN))     len = CNT_W'(MAX_LEN);
    else                                          len = window_length;
  end

  assign head_eff = (CW'(head_r) >= CW'(len)) ? '0 : head_r;
  assign was_full = !(count_r < len);
  assign next_pos = CW1'(idx_r) + CW1'(1);

  always_comb begin
    if (item_r.cmd == CMD_CLEAR) begin
      head_upd  = '0;
      count_upd = '0;
      sum_upd   = '0;
    end else begin
      head_upd  = (next_pos >= CW1'(len)) ? '0 : HW'(next_pos);
      count_upd = was_full ? count_r : count_r + CNT_W'(1);
      sum_upd   = sum_r + SUM_W'($signed(item_r.sample))
                - (was_full ? SUM_W'($signed(rdata_r)) : SUM_W'(0));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (item_valid) state_nxt = B_READ;
      B_READ:   state_nxt = B_UPDATE;
      B_UPDATE: state_nxt = (count_upd == '0) ? B_OUT : B_DIV;
      B_DIV:    if (div_rsp.done) state_nxt = B_OUT;
      B_OUT:    if (!out_valid_r || out_ready) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    item_pop         = 1'b0;
    rd_en            = 1'b0;
    ring_we          = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_upd;
    div_req.divisor  = count_upd;
    unique case (state_r)
      B_IDLE:   item_pop = item_valid;
      B_READ:   rd_en = 1'b1;
      B_UPDATE: begin
        ring_we       = (item_r.cmd == CMD_PUSH);
        div_req.start = (count_upd != '0);
      end
      B_DIV:    ;
      B_OUT:    out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_UPDATE) begin
        head_r  <= head_upd;
        count_r <= count_upd;
        sum_r   <= sum_upd;
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      item_r <= item;
      idx_r  <= head_eff;
    end
    if (state_r == B_UPDATE && count_upd == '0) begin
      avg_r <= '0;
    end else if (state_r == B_DIV && div_rsp.done) begin
      avg_r <= div_rsp.quotient;
    end
    if (out_load) begin
      out_avg_r  <= avg_r;
      out_full_r <= (count_r == len);
      out_fill_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_r[idx_r] <= item_r.sample;
    end
    if (rd_en) begin
      rdata_r <= ring_r[idx_r];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;
  assign out_full    = out_full_r;
  assign out_fill    = out_fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_LEN)
    else $error("fill count above the largest window");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(head_r) < MAX_WINDOW)
    else $error("write head outside the ring");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == B_DIV)
    else $error("divider finished while no division was pending");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_UPDATE && item_r.cmd == CMD_CLEAR) |=>
      (count_r == '0 && sum_r == '0 && head_r == '0))
    else $error("clear did not empty the window");

endmodule

/* rtl/core/moving_average_window_core.sv */
// Top level of the moving average window core.
// Instantiates mavg_front, mavg_back and mavg_div; uses mavg_pkg.
//
// Usage:
//   Input items arrive on the in_ stream. in_tuser selects the command
//   (0 pushes in_tdata as a signed sample into the window, 1 clears the
//   window). Every item yields exactly one result item on the out_ stream:
//   the mean of the held samples truncated toward zero (0 when the window is
//   empty), the fill count and a window-full flag.
//   The window length is written through cfg_wr_en / cfg_wr_data while the
//   block is idle; a clear item must follow every change of the length.
// Timing:
//   A push passes the back end states B_READ, B_UPDATE and B_DIV, and its
//   result is loaded into the output register in B_OUT; a clear skips B_DIV.
//   The push time is set by the bit-serial divider, which produces one
//   quotient bit per cycle over the 22-bit running sum. Items are carried
//   out one at a time; the next item is popped once the result is loaded.
// Reset and stalls:
//   rst_n (synchronous, active low) empties the window, clears the input
//   queue, drops any pending result and sets the window length to 16. Ring
//   contents are not cleared; with a clear after each length change, an entry
//   leaves the sum only after it was written. While out_tready is low the
//   result waits in the output register and the two-entry input queue keeps
//   accepting items until full.
module moving_average_window_core
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SAMPLE_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                 in_tuser,   // [0] command
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [15:0] average, [22:16] fill_count
  output logic                 out_tuser,  // [0] window_full
  // Configuration.
  input  logic                 cfg_wr_en,
  input  logic [CNT_W-1:0]     cfg_wr_data // [6:0] window_length
);

  logic [CNT_W-1:0]    window_length_r;
  q_item_t             item;
  logic                item_valid;
  logic                item_pop;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [SAMPLE_W-1:0] res_average;
  logic                res_full;
  logic [CNT_W-1:0]    res_fill;

  // The window length register is the only configuration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_length_r <= cfg_wr_data;
    end
  end

  // Front end: accepts items and buffers them for the back end.
  mavg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // Back end: updates the window state and sequences the division.
  mavg_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_length (window_length_r),
    .item          (item),
    .item_valid    (item_valid),
    .item_pop      (item_pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_average   (res_average),
    .out_full      (res_full),
    .out_fill      (res_fill)
  );

  // Bit-serial divider for the average, driven by the back end.
  mavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tdata = {1'b0, res_fill, res_average};
  assign out_tuser = res_full;

endmodule

/* sim/moving_average_window_core_tb.sv */
// Self-checking testbench for moving_average_window_core.
// Drives the in_/cfg_ ports, checks every out_ item against a local predictor or a typed row.
// Depends on mavg_pkg and the RTL under rtl/core only.
module moving_average_window_core_tb
  import mavg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int RANDOM_ITEMS   = 1930;
  localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off
  localparam int DRAIN_CYCLES   = 64;    // watch time for stray result items at the end
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
  localparam int PLAN_LEN       = 25;

  // One expected result item: average, window-full flag and fill count.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                full;
    logic [CNT_W-1:0]    fill;
  } mean_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_WINDOW
  } row_kind_t;

  // A directed row either sends one item or rewrites the window length.
  // When typed is set, the expected result is the one given in the row.
  typedef struct {
    row_kind_t           kind;
    cmd_t                cmd;
    logic [SAMPLE_W-1:0] value;
    bit                  typed;
    logic [SAMPLE_W-1:0] mean;
    logic                full;
    logic [CNT_W-1:0]    fill;
  } plan_row_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata    = '0;
  logic                in_tuser    = 1'b0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [23:0]         out_tdata;
  logic                out_tuser;
  logic                cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data = '0;

  // Predictor state: a private copy of the window.
  logic signed [SAMPLE_W-1:0] ring_copy [DEFAULT_MAX_WINDOW];
  bit                         ring_written [DEFAULT_MAX_WINDOW];
  logic [CNT_W-1:0]           win_len_reg;
  int                         head_pos;
  int                         held_samples;
  logic signed [SUM_W-1:0]    acc_sum;

  mean_result_t expected_means [$];
  int           mismatches   = 0;
  int           quiet_cycles = 0;

  // Shared between the stimulus and the checker / receiver processes.
  bit           typed_row     = 1'b0;
  mean_result_t typed_want;
  bit           burst_phase   = 1'b0;
  bit           hold_off_req  = 1'b0;

  plan_row_t plan [PLAN_LEN];

  moving_average_window_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor helpers.
  // ---------------------------------------------------------------------------

  // A length of zero behaves as one; anything above the ring size saturates.
  function automatic int eff_len();
    if (win_len_reg == '0) return 1;
    if (int'(win_len_reg) > DEFAULT_MAX_WINDOW) return DEFAULT_MAX_WINDOW;
    return int'(win_len_reg);
  endfunction

  // A head left past the end by a shrinking window falls back to entry zero.
  function automatic int ring_slot(input int len);
    return (head_pos >= len) ? 0 : head_pos;
  endfunction

  // The running sum is a 22-bit two's complement register and wraps.
  function automatic logic signed [SUM_W-1:0] wrap_sum(input int v);
    return v[SUM_W-1:0];
  endfunction

  // A push only reads the ring when the window is already full. Random
  // stimulus never lets such a read land on an entry that was never written.
  function automatic bit push_is_safe();
    int len;
    len = eff_len();
    return (held_samples < len) || ring_written[ring_slot(len)];
  endfunction

  // Apply one accepted item to the window copy and work out its result.
  task automatic advance_window(input cmd_t cmd, input logic signed [SAMPLE_W-1:0] smp,
                                output mean_result_t res);
    int len;
    int slot;
    int quo;
    len = eff_len();
    if (cmd == CMD_CLEAR) begin
      head_pos     = 0;
      held_samples = 0;
      acc_sum      = '0;
    end else begin
      slot = ring_slot(len);
      if (held_samples < len) begin
        held_samples++;
      end else begin
        // Full window: the oldest sample leaves the sum.
        acc_sum = wrap_sum(int'(acc_sum) - int'(ring_copy[slot]));
      end
      ring_copy[slot]    = smp;
      ring_written[slot] = 1'b1;
      acc_sum            = wrap_sum(int'(acc_sum) + int'(smp));
      slot++;
      head_pos = (slot >= len) ? 0 : slot;
    end
    res.mean = '0;
    if (held_samples != 0) begin
      // SystemVerilog integer division truncates toward zero, as required.
      quo = int'(acc_sum) / held_samples;
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      res.mean = quo[SAMPLE_W-1:0];
    end
    res.full = (held_samples == len);
    res.fill = held_samples[CNT_W-1:0];
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Checker: updates the predictor on accepted input items and configuration
  // writes, and compares every accepted result item with the oldest
  // expectation. Everything is sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mean_result_t predicted;
    mean_result_t want;
    if (!rst_n) begin
      win_len_reg  = WIN_RESET;
      head_pos     = 0;
      held_samples = 0;
      acc_sum      = '0;
      foreach (ring_written[i]) ring_written[i] = 1'b0;
    end else begin
      if (cfg_wr_en) win_len_reg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        advance_window(cmd_t'(in_tuser), in_tdata, predicted);
        // Rows with a hand-written answer are checked against that answer.
        expected_means.push_back(typed_row ? typed_want : predicted);
      end
      if (out_tvalid && out_tready) begin
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("result item with nothing expected: tdata %h tuser %b",
                                    out_tdata, out_tuser));
        end else begin
          want = expected_means.pop_front();
          if (out_tdata[15:0] !== want.mean)
            report_mismatch($sformatf("average got %0d expected %0d",
                                      $signed(out_tdata[15:0]), $signed(want.mean)));
          if (out_tdata[22:16] !== want.fill)
            report_mismatch($sformatf("fill_count got %0d expected %0d",
                                      out_tdata[22:16], want.fill));
          if (out_tuser !== want.full)
            report_mismatch($sformatf("window_full got %b expected %b",
                                      out_tuser, want.full));
        end
      end
    end
  end

  // The run ends as a failure if no item moves on any port for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Random choices.
  // ---------------------------------------------------------------------------

  // Idle stretches: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Samples lean on the two extremes and on values near zero, where the
  // truncation toward zero is easiest to get wrong.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r < 4) return 16'($urandom_range(0, 64) - 32);
    return 16'($urandom);
  endfunction

  // Window lengths include zero and values past the ring size.
  function automatic logic [CNT_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd1;
    if (r == 1) return 7'd64;
    if (r == 2) return 7'd0;
    if (r == 3) return 7'($urandom_range(65, 127));
    if (r == 4) return 7'd2;
    return 7'($urandom_range(1, 64));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks. Each one is entered just after a falling edge, so the
  // checker has already absorbed the handshakes of the last rising edge.
  // ---------------------------------------------------------------------------

  // Offer one item after an optional gap and hold it until it is accepted.
  task automatic send_item(input cmd_t cmd, input logic [SAMPLE_W-1:0] smp, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering items until every expected result item has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // The length may only change while the block is idle. Every item yields a
  // result item, so an empty expectation queue means nothing is in flight.
  task automatic set_window(input logic [CNT_W-1:0] len);
    typed_row = 1'b0;
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready with idle stretches, ready held high through burst
  // phases, and one long hold-off on request, counted here.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_count;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (burst_phase || stall_left == 0) begin
        out_tready <= 1'b1;
        stall_left = burst_phase ? 0 : pick_gap();
      end else begin
        out_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random phases.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int phase_len;
    int rand_items;
    int clear_odds;
    int k;

    // Directed table. Window rows without a clear after them exercise a
    // length change on a filled window, including a head left past the end.
    plan = '{
      '{ROW_ITEM,   CMD_CLEAR, 16'h0000, 1'b1, 16'h0000, 1'b0, 7'd0},  // empty window
      '{ROW_ITEM,   CMD_PUSH,  16'h7FFF, 1'b1, 16'h7FFF, 1'b0, 7'd1},  // largest sample
      '{ROW_ITEM,   CMD_PUSH,  16'h8000, 1'b0, 16'h0000, 1'b0, 7'd0},  // -1/2 truncates to 0
      '{ROW_ITEM,   CMD_PUSH,  16'hFFFF, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_WINDOW, CMD_PUSH,  16'h0000, 1'b0, 16'h0000, 1'b0, 7'd0},  // zero acts as one
      '{ROW_ITEM,   CMD_PUSH,  16'h0005, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_CLEAR, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'h8000, 1'b1, 16'h8000, 1'b1, 7'd1},  // full at one sample
      '{ROW_ITEM,   CMD_PUSH,  16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 7'd1},
      '{ROW_WINDOW, CMD_PUSH,  16'h007F, 1'b0, 16'h0000, 1'b0, 7'd0},  // saturates to 64
      '{ROW_ITEM,   CMD_CLEAR, 16'h0000, 1'b1, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'h8000, 1'b1, 16'h8000, 1'b0, 7'd1},  // smallest sample
      '{ROW_ITEM,   CMD_PUSH,  16'hFFFF, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'h5555, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'hAAAA, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_WINDOW, CMD_PUSH,  16'h0002, 1'b0, 16'h0000, 1'b0, 7'd0},  // shrink below the fill
      '{ROW_ITEM,   CMD_PUSH,  16'h0064, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'hFF9C, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_CLEAR, 16'h5555, 1'b1, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'h0007, 1'b1, 16'h0007, 1'b0, 7'd1},
      '{ROW_ITEM,   CMD_PUSH,  16'h0009, 1'b1, 16'h0008, 1'b1, 7'd2},
      '{ROW_ITEM,   CMD_PUSH,  16'h000A, 1'b0, 16'h0000, 1'b0, 7'd0},  // oldest sample replaced
      '{ROW_WINDOW, CMD_PUSH,  16'h0010, 1'b0, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_CLEAR, 16'h0000, 1'b1, 16'h0000, 1'b0, 7'd0},
      '{ROW_ITEM,   CMD_PUSH,  16'h0000, 1'b1, 16'h0000, 1'b0, 7'd1}
    };

    // Reset is held low from the start and never asserted again.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      @(negedge clk);
      typed_row       = plan[i].typed;
      typed_want.mean = plan[i].mean;
      typed_want.full = plan[i].full;
      typed_want.fill = plan[i].fill;
      if (plan[i].kind == ROW_WINDOW) set_window(plan[i].value[CNT_W-1:0]);
      else send_item(plan[i].cmd, plan[i].value, pick_gap());
    end

    // Random phases. The first one uses the full ring so that every entry
    // is written early on. Later phases sometimes skip the clear after a
    // length change. Every fourth phase runs without idling on either side,
    // one phase starts with a long receiver hold-off, and a few phases are
    // noisy, with clears breaking up the fill.
    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      @(negedge clk);
      set_window((phase == 0) ? 7'd64 : pick_window());
      burst_phase = (phase % 4 == 1);
      if (phase == 2) hold_off_req = 1'b1;
      clear_odds = (phase % 5 == 3) ? 6 : 90;
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        @(negedge clk);
        send_item(CMD_CLEAR, 16'($urandom), 0);
        rand_items++;
      end
      phase_len = $urandom_range(100, 220);
      for (k = 0; k < phase_len && rand_items < RANDOM_ITEMS; k++) begin
        @(negedge clk);
        if (!burst_phase && $urandom_range(0, 149) == 0) wait_for_results();
        if ($urandom_range(1, clear_odds) == 1 || !push_is_safe())
          send_item(CMD_CLEAR, 16'($urandom), burst_phase ? 0 : pick_gap());
        else
          send_item(CMD_PUSH, pick_sample(), burst_phase ? 0 : pick_gap());
        rand_items++;
      end
      phase++;
    end

    // Let the last results come back, then watch for stray result items.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mavg_pkg.sv
rtl/core/mavg_front.sv
rtl/core/mavg_div.sv
rtl/core/mavg_back.sv
rtl/core/moving_average_window_core.sv
sim/moving_average_window_core_tb.sv
